// ===== src/dfm_pkg.sv =====
// ----------------------------------------------------------------------------
// dfm_pkg - shared definitions for the data freshness monitor
// Widths, channel map, freshness codes and the types that pass between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package dfm_pkg;

    localparam int CHANNELS  = 10;
    localparam int TIME_BITS = 48;

    localparam int WORD_W    = 32;
    localparam int SRC_W     = 8;
    localparam int TS_W      = 48;
    localparam int ELAPSED_W = 16;
    localparam int LIMIT_W   = 32;
    localparam int GROUP_W   = 3;
    localparam int CODE_W    = 2;
    localparam int CODES_W   = CODE_W * CHANNELS;
    localparam int CFG_IDX_W = 1;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_PUBLISH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID = 1'b1;

    localparam logic [LIMIT_W-1:0] STALE_RESET   = LIMIT_W'(5000);
    localparam logic [LIMIT_W-1:0] INVALID_RESET = LIMIT_W'(30000);

    localparam logic [CODE_W-1:0] CODE_FRESH   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_STALE   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_INVALID = 2'd2;
    localparam logic [CODE_W-1:0] CODE_UNUSED  = 2'd3;

    localparam logic [GROUP_W-1:0] GRP_POSITION  = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_COURSE    = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_HEADING   = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_DEPTH     = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_WIND      = 3'd4;
    localparam logic [GROUP_W-1:0] GRP_VARIATION = 3'd5;

    typedef struct packed {
        logic                 op;
        logic [GROUP_W-1:0]   group;
        logic [WORD_W-1:0]    value_a;
        logic [WORD_W-1:0]    value_b;
        logic                 has_second;
        logic [SRC_W-1:0]     source_id;
        logic                 has_timestamp;
        logic [TS_W-1:0]      timestamp_ms;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [LIMIT_W-1:0]   data;
    } cfg_wr_t;

    typedef struct packed {
        logic               valid;
        logic               changed;
        logic [CODES_W-1:0] codes;
    } res_t;

    typedef struct packed {
        logic            ok;
        logic [CH_W-1:0] first;
        logic            two;
        logic [CH_W-1:0] second;
    } grp_map_t;

    function automatic grp_map_t grp_map(input logic [GROUP_W-1:0] g);
        grp_map_t m;
        m = '{ok: 1'b1, first: '0, two: 1'b0, second: '0};
        case (g)
            GRP_POSITION: begin
                m.first = CH_W'(0); m.two = 1'b1; m.second = CH_W'(1);
            end
            GRP_COURSE: begin
                m.first = CH_W'(2); m.two = 1'b1; m.second = CH_W'(3);
            end
            GRP_HEADING: begin
                m.first = CH_W'(4); m.two = 1'b1; m.second = CH_W'(5);
            end
            GRP_DEPTH: begin
                m.first = CH_W'(7);
            end
            GRP_WIND: begin
                m.first = CH_W'(8); m.two = 1'b1; m.second = CH_W'(9);
            end
            GRP_VARIATION: begin
                m.first = CH_W'(6);
            end
            default: begin
                m.ok = 1'b0;
            end
        endcase
        return m;
    endfunction

    // true when no channel carries the unused code
    function automatic logic codes_ok(input logic [CODES_W-1:0] c);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (c[CODE_W*i +: CODE_W] == CODE_UNUSED) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== src/dfm_ram.sv =====
// ----------------------------------------------------------------------------
// dfm_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dfm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/dfm_core.sv =====
// ----------------------------------------------------------------------------
// dfm_core - channel store and aging sequencer
// Publishes write channel entries to the memories; ticks sweep the stamp
// memory one channel per cycle and reclassify each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dfm_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire dfm_pkg::cfg_wr_t cfg,
    input  wire logic            in_valid,
    input  wire dfm_pkg::item_t  in_item,
    output logic                 in_ready,
    output dfm_pkg::res_t        res,
    input  wire logic            res_ready
);
    import dfm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUB_A,
        ST_PUB_B,
        ST_TICK,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [LIMIT_W-1:0]   stale_reg;
    logic [LIMIT_W-1:0]   invalid_reg;
    logic [TIME_BITS-1:0] clock_reg;
    logic                 set_reg   [CHANNELS];
    logic [CODE_W-1:0]    fresh_reg [CHANNELS];
    logic                 changed_reg;
    logic [CNT_W-1:0]     rd_cnt_reg;
    logic                 cmp_vld_reg;
    logic [CH_W-1:0]      cmp_ch_reg;

    // latched item payload
    grp_map_t             map_reg;
    logic                 two_reg;
    logic [WORD_W-1:0]    value_a_reg;
    logic [WORD_W-1:0]    value_b_reg;
    logic [SRC_W-1:0]     source_reg;
    logic [TIME_BITS-1:0] stamp_reg;

    grp_map_t             map_in;
    logic                 wr_en;
    logic [CH_W-1:0]      wr_ch;
    logic [WORD_W-1:0]    wr_word;
    logic                 rd_en;
    logic [TIME_BITS-1:0] rd_stamp;
    logic [CODE_W-1:0]    code_new;
    logic [TIME_BITS-1:0] age;
    logic [CODES_W-1:0]   codes;

    assign map_in   = grp_map(in_item.group);
    assign in_ready = (state_reg == ST_IDLE);

    assign wr_en   = (state_reg == ST_PUB_A) || (state_reg == ST_PUB_B);
    assign wr_ch   = (state_reg == ST_PUB_A) ? map_reg.first : map_reg.second;
    assign wr_word = (state_reg == ST_PUB_A) ? value_a_reg : value_b_reg;

    assign rd_en = (state_reg == ST_TICK) && (rd_cnt_reg < CNT_W'(CHANNELS));

    dfm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (CHANNELS)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ch),
        .wr_data (stamp_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[CH_W-1:0]),
        .rd_data (rd_stamp)
    );

    // value word and source are kept but never read back
    dfm_ram #(
        .WIDTH (SRC_W + WORD_W),
        .DEPTH (CHANNELS)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ch),
        .wr_data ({source_reg, wr_word}),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    // stamp ahead of the clock counts as fresh
    assign age = clock_reg - rd_stamp;
    always_comb begin
        if (!set_reg[cmp_ch_reg]) begin
            code_new = CODE_INVALID;
        end else if (rd_stamp > clock_reg) begin
            code_new = CODE_FRESH;
        end else if (age < TIME_BITS'(stale_reg)) begin
            code_new = CODE_FRESH;
        end else if (age < TIME_BITS'(invalid_reg)) begin
            code_new = CODE_STALE;
        end else begin
            code_new = CODE_INVALID;
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            codes[CODE_W*i +: CODE_W] = fresh_reg[i];
        end
    end

    assign res.valid   = (state_reg == ST_OUT);
    assign res.changed = changed_reg;
    assign res.codes   = codes;

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            map_reg     <= map_in;
            two_reg     <= map_in.two &&
                           ((in_item.group != GRP_HEADING) || in_item.has_second);
            value_a_reg <= in_item.value_a;
            value_b_reg <= in_item.value_b;
            source_reg  <= in_item.source_id;
            stamp_reg   <= in_item.has_timestamp ? TIME_BITS'(in_item.timestamp_ms)
                                                 : clock_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stale_reg   <= STALE_RESET;
            invalid_reg <= INVALID_RESET;
            clock_reg   <= '0;
            changed_reg <= 1'b0;
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_ch_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                set_reg[i]   <= 1'b0;
                fresh_reg[i] <= CODE_INVALID;
            end
        end else begin
            if (cfg.en) begin
                case (cfg.idx)
                    CFG_STALE:   stale_reg   <= cfg.data;
                    CFG_INVALID: invalid_reg <= cfg.data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        if (in_item.op == OP_TICK) begin
                            clock_reg   <= clock_reg + TIME_BITS'(in_item.elapsed_ms);
                            rd_cnt_reg  <= '0;
                            cmp_vld_reg <= 1'b0;
                            changed_reg <= 1'b0;
                            state_reg   <= ST_TICK;
                        end else if (map_in.ok) begin
                            changed_reg <= 1'b1;
                            state_reg   <= ST_PUB_A;
                        end else begin
                            changed_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_PUB_A, ST_PUB_B: begin
                    set_reg[wr_ch]   <= 1'b1;
                    fresh_reg[wr_ch] <= CODE_FRESH;
                    if (state_reg == ST_PUB_A && two_reg) begin
                        state_reg <= ST_PUB_B;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_TICK: begin
                    // read one stamp per cycle, classify it the cycle after
                    cmp_vld_reg <= rd_en;
                    if (rd_en) begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                        cmp_ch_reg <= rd_cnt_reg[CH_W-1:0];
                    end
                    if (cmp_vld_reg) begin
                        fresh_reg[cmp_ch_reg] <= code_new;
                        if (code_new != fresh_reg[cmp_ch_reg]) begin
                            changed_reg <= 1'b1;
                        end
                        if (cmp_ch_reg == CH_W'(CHANNELS - 1)) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/data_freshness_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// data_freshness_monitor_unit - freshness tracking for timestamped channels
// Publishes stamp sensor channels; ticks advance the clock and age them.
//
//  port group    dir   payload
//  s_*           in    item: tuser operation, tdata group .. elapsed_ms
//  m_*           out   result: tdata changed, freshness_codes
//  cfg_wr_*      in    limit registers, no read-back
//
// Tick: advances the clock, then sweeps the stamp memory at one read per
// cycle and classifies each channel. Publish: one or two channel writes;
// a group outside 0..5 writes nothing. The result sits in an output
// register, so the next beat is taken while it waits on m_tready.
// aresetn is synchronous; channel value/stamp memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module data_freshness_monitor_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dfm_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [dfm_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // group, value_a, value_b, has_second, source_id, has_timestamp,
    // timestamp_ms, elapsed_ms, zero pad
    input  wire logic [143:0]                  s_tdata,
    // operation
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // changed, freshness_codes, zero pad
    output logic [23:0]                        m_tdata
);
    import dfm_pkg::*;

    localparam int OUT_W = 1 + CODES_W;

    item_t   item;
    cfg_wr_t cfg;
    res_t    res;
    logic    res_ready;
    logic    m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    assign item.op            = s_tuser;
    assign item.group         = s_tdata[2:0];
    assign item.value_a       = s_tdata[34:3];
    assign item.value_b       = s_tdata[66:35];
    assign item.has_second    = s_tdata[67];
    assign item.source_id     = s_tdata[75:68];
    assign item.has_timestamp = s_tdata[76];
    assign item.timestamp_ms  = s_tdata[124:77];
    assign item.elapsed_ms    = s_tdata[140:125];

    assign cfg.en   = cfg_wr_en;
    assign cfg.idx  = cfg_wr_index;
    assign cfg.data = cfg_wr_data;

    assign res_ready = !m_valid_reg || m_tready;

    dfm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_item   (item),
        .in_ready  (s_tready),
        .res       (res),
        .res_ready (res_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            m_data_reg <= {res.codes, res.changed};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 24'(m_data_reg);

    // one item at a time: an accepted beat closes the input until the core hands on its result
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // only the three defined codes reach the output
    a_codes_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> codes_ok(m_tdata[CODES_W:1]))
        else $error("undefined freshness code on output");

    // a pending result is never dropped by a new one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result lost or changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
